FILE: hw/rtl/pdilc_pkg.sv
package pdilc_pkg;

  // Trajectory store and joint count
  localparam int TRAJ_DEPTH = 1024;
  localparam int JOINTS     = 4;
  localparam int NJ         = 4;
  localparam int IDX_W      = (TRAJ_DEPTH > 1) ? $clog2(TRAJ_DEPTH) : 1;
  localparam int FILL_W     = $clog2(TRAJ_DEPTH + 1);

  // Field widths
  localparam int DATA_W     = 32;
  localparam int SIDX_W     = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int FRAC_SHIFT = 8;

  typedef logic [IDX_W-1:0] idx_t;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P_0 = 4'd0,
    CFG_GAIN_P_1 = 4'd1,
    CFG_GAIN_P_2 = 4'd2,
    CFG_GAIN_P_3 = 4'd3,
    CFG_GAIN_D_0 = 4'd4,
    CFG_GAIN_D_1 = 4'd5,
    CFG_GAIN_D_2 = 4'd6,
    CFG_GAIN_D_3 = 4'd7
  } cfg_reg_e;

  localparam logic signed [DATA_W-1:0] GAIN_P_RST [NJ] = '{
    32'sd2560000, 32'sd2560000, 32'sd2560000, 32'sd12800000
  };
  localparam logic signed [DATA_W-1:0] GAIN_D_RST [NJ] = '{
    32'sd25600, 32'sd25600, 32'sd25600, 32'sd128000
  };

  // Pipeline control shared by all joint lanes
  typedef struct packed {
    logic ld1;          // stage 1 loads
    logic ld2;          // stage 2 loads
    logic ld3;          // stage 3 loads
    logic ld4;          // stage 4 loads
    logic err_we;       // input transfer: write error row
    idx_t rd_idx;       // current trajectory index
    idx_t rd_next_idx;  // following index
    logic v1;           // stage 1 holds an item
    logic ok_this1;     // entry at index was written before
    logic ok_next1;     // entry at next index was written before
    logic wrap1;        // next error comes from first-sample store
    logic zero1;        // item sits at index zero
    idx_t idx3;         // action read address
    logic act_ok4;      // action entry was written before
    logic fwd4;         // action comes from the item just ahead
    logic act_we;       // stage 4 moves to output: write action row
    idx_t idx4;         // action write address
  } ctl_t;

endpackage

FILE: hw/rtl/pdilc_lane.sv
module pdilc_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pdilc_pkg::ctl_t                     ctl_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] pos_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] ref_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] gain_p_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] gain_d_i,
  output logic signed [pdilc_pkg::DATA_W-1:0] action_o
);
  import pdilc_pkg::*;

  localparam int DIFF_W = DATA_W + 1;
  localparam int P1_W   = 2 * DATA_W;
  localparam int P2_W   = 2 * DATA_W + 1;
  localparam int SUM_W  = P2_W + 1;
  localparam int SHR_W  = SUM_W - FRAC_SHIFT;
  localparam int U_W    = SHR_W + 1;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] err_mem [TRAJ_DEPTH];
  logic [DATA_W-1:0] act_mem [TRAJ_DEPTH];

  logic signed [DIFF_W-1:0] e_wide;
  logic signed [DATA_W-1:0] e_now;

  logic signed [DATA_W-1:0] rd_this_q, rd_next_q;
  logic signed [DATA_W-1:0] e_this, e_nxt_mem, e_next;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DATA_W-1:0] first_q;

  logic signed [DATA_W-1:0] e_next_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [P1_W-1:0]   p1;
  logic signed [P2_W-1:0]   p2;

  logic signed [P1_W-1:0]   p1_q;
  logic signed [P2_W-1:0]   p2_q;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SHR_W-1:0]  shr;

  logic signed [SHR_W-1:0]  shr_q;
  logic signed [DATA_W-1:0] rd_act_q;
  logic signed [DATA_W-1:0] u_old;
  logic signed [U_W-1:0]    u;
  logic signed [DATA_W-1:0] u_sat;
  logic signed [DATA_W-1:0] action_q;

  // Saturate the new error to 32 bits
  always_comb begin
    e_wide = {ref_i[DATA_W-1], ref_i} - {pos_i[DATA_W-1], pos_i};
    if (e_wide[DIFF_W-1] != e_wide[DATA_W-1]) begin
      e_now = e_wide[DIFF_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      e_now = e_wide[DATA_W-1:0];
    end
  end

  // Error store: read this and next entry, overwrite this entry on transfer
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld1) begin
      rd_this_q <= err_mem[ctl_i.rd_idx];
      rd_next_q <= err_mem[ctl_i.rd_next_idx];
    end
    if (ctl_i.err_we) begin
      err_mem[ctl_i.rd_idx] <= e_now;
    end
  end

  // Stage 1: pick errors, entries never written read as zero
  always_comb begin
    e_this    = ctl_i.ok_this1 ? rd_this_q : '0;
    e_nxt_mem = ctl_i.ok_next1 ? rd_next_q : '0;
    if (ctl_i.wrap1) begin
      e_next = ctl_i.zero1 ? e_this : first_q;
    end else begin
      e_next = e_nxt_mem;
    end
    diff = {e_this[DATA_W-1], e_this} - {e_next[DATA_W-1], e_next};
  end

  // Capture last trial's error at index zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
    end else if (ctl_i.ld2 && ctl_i.v1 && ctl_i.zero1) begin
      first_q <= e_this;
    end
  end

  // Stage 2: gain products
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld2) begin
      e_next_q <= e_next;
      diff_q   <= diff;
    end
  end

  assign p1 = gain_p_i * e_next_q;
  assign p2 = gain_d_i * diff_q;

  // Stage 3: sum products and floor to Q16.16
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld3) begin
      p1_q <= p1;
      p2_q <= p2;
    end
  end

  assign sum = SUM_W'(p1_q) + SUM_W'(p2_q);
  assign shr = $signed(sum[SUM_W-1:FRAC_SHIFT]);

  // Action store: read ahead of stage 4, write as stage 4 moves out
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld4) begin
      rd_act_q <= act_mem[ctl_i.idx3];
      shr_q    <= shr;
    end
    if (ctl_i.act_we) begin
      act_mem[ctl_i.idx4] <= u_sat;
      action_q            <= u_sat;
    end
  end

  // Stage 4: add old action and saturate
  always_comb begin
    if (ctl_i.fwd4) begin
      u_old = action_q;
    end else begin
      u_old = ctl_i.act_ok4 ? rd_act_q : '0;
    end
    u = U_W'(shr_q) + U_W'(u_old);
    if (u[U_W-1:DATA_W-1] == '0 || u[U_W-1:DATA_W-1] == '1) begin
      u_sat = u[DATA_W-1:0];
    end else begin
      u_sat = u[U_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  assign action_o = action_q;

endmodule

FILE: hw/rtl/pdilc_ctrl.sv
module pdilc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           last_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pdilc_pkg::SIDX_W-1:0]   sample_index_o,
  output pdilc_pkg::ctl_t                ctl_o
);
  import pdilc_pkg::*;

  idx_t              idx_q;
  logic [FILL_W-1:0] err_fill_q, act_fill_q;
  logic              v1_q, v2_q, v3_q, v4_q, vo_q;
  logic              ld1, ld2, ld3, ld4, ldo;
  logic              accept, wrap, act_we;
  idx_t              idx_next;
  logic [FILL_W-1:0] idx_f, idx_nf;
  logic              ok_this, ok_next, ok_act, fwd;

  idx_t              idx1_q, idx2_q, idx3_q, idx4_q;
  logic              wrap1_q, zero1_q, ok_this1_q, ok_next1_q;
  logic              act_ok4_q, fwd4_q;
  logic [31:0]       idx4_w;
  logic [SIDX_W-1:0] sidx_q;

  // Stage load enables: a stage loads when empty or when it moves on
  assign ldo = !vo_q || !out_stall_i;
  assign ld4 = !v4_q || ldo;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  assign accept = in_valid_i && ld1;
  assign act_we = ldo && v4_q;

  // Index and fill-count lookups
  always_comb begin
    wrap     = last_sample_i || (idx_q == IDX_W'(TRAJ_DEPTH - 1));
    idx_next = idx_q + IDX_W'(1);
    idx_f    = FILL_W'(idx_q);
    idx_nf   = idx_f + FILL_W'(1);
    ok_this  = idx_f < err_fill_q;
    ok_next  = idx_nf < err_fill_q;
    ok_act   = FILL_W'(idx3_q) < act_fill_q;
    fwd      = v4_q && (idx4_q == idx3_q);
  end

  // Valid bits, trial index and fill counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      vo_q       <= 1'b0;
      idx_q      <= '0;
      err_fill_q <= '0;
      act_fill_q <= '0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q;
      if (ldo) vo_q <= v4_q;
      if (accept) begin
        idx_q <= wrap ? '0 : idx_next;
        if (idx_f == err_fill_q) begin
          err_fill_q <= err_fill_q + FILL_W'(1);
        end
      end
      if (act_we && (FILL_W'(idx4_q) == act_fill_q)) begin
        act_fill_q <= act_fill_q + FILL_W'(1);
      end
    end
  end

  // Per-stage index and flags travel with the item
  assign idx4_w = 32'(idx4_q);

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      idx1_q     <= idx_q;
      wrap1_q    <= wrap;
      zero1_q    <= (idx_q == '0);
      ok_this1_q <= ok_this;
      ok_next1_q <= ok_next;
    end
    if (ld2) idx2_q <= idx1_q;
    if (ld3) idx3_q <= idx2_q;
    if (ld4) begin
      idx4_q    <= idx3_q;
      act_ok4_q <= ok_act;
      fwd4_q    <= fwd;
    end
    if (act_we) sidx_q <= idx4_w[SIDX_W-1:0];
  end

  always_comb begin
    ctl_o             = '0;
    ctl_o.ld1         = ld1;
    ctl_o.ld2         = ld2;
    ctl_o.ld3         = ld3;
    ctl_o.ld4         = ld4;
    ctl_o.err_we      = accept;
    ctl_o.rd_idx      = idx_q;
    ctl_o.rd_next_idx = idx_next;
    ctl_o.v1          = v1_q;
    ctl_o.ok_this1    = ok_this1_q;
    ctl_o.ok_next1    = ok_next1_q;
    ctl_o.wrap1       = wrap1_q;
    ctl_o.zero1       = zero1_q;
    ctl_o.idx3        = idx3_q;
    ctl_o.act_ok4     = act_ok4_q;
    ctl_o.fwd4        = fwd4_q;
    ctl_o.act_we      = act_we;
    ctl_o.idx4        = idx4_q;
  end

  assign in_stall_o     = !ld1;
  assign out_valid_o    = vo_q;
  assign sample_index_o = sidx_q;

endmodule

FILE: hw/rtl/pd_iterative_learning_controller.sv
// Channel   Handshake                 Payload
// --------  ------------------------  -------------------------------------------
// in        in_valid_i / in_stall_o   pos_0..3_i, ref_0..3_i, last_sample_i
// out       out_valid_o / out_stall_i action_0..3_o, sample_index_o
// cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i (gain registers)
//
// One sample per cycle unless the output stalls; each result passes through
// stage 1 (store read), stage 2 (gain multipliers), stage 3 (product sum),
// stage 4 (old-action add and saturation) and the output register.
// Reset clears the gains to their defaults and the index to zero. The stores
// hold no reset: fill counts mark which rows were written, others read as zero.
// A stall on the output holds every full stage; the input stalls only when full.
module pd_iterative_learning_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pdilc_pkg::DATA_W-1:0] pos_0_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] pos_1_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] pos_2_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] pos_3_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] ref_0_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] ref_1_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] ref_2_i,
  input  logic signed [pdilc_pkg::DATA_W-1:0] ref_3_i,
  input  logic                                last_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pdilc_pkg::DATA_W-1:0] action_0_o,
  output logic signed [pdilc_pkg::DATA_W-1:0] action_1_o,
  output logic signed [pdilc_pkg::DATA_W-1:0] action_2_o,
  output logic signed [pdilc_pkg::DATA_W-1:0] action_3_o,
  output logic [pdilc_pkg::SIDX_W-1:0]        sample_index_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pdilc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pdilc_pkg::DATA_W-1:0]        cfg_data_i
);
  import pdilc_pkg::*;

  logic signed [DATA_W-1:0] gain_p_q [NJ];
  logic signed [DATA_W-1:0] gain_d_q [NJ];
  logic signed [DATA_W-1:0] pos_a    [NJ];
  logic signed [DATA_W-1:0] ref_a    [NJ];
  logic signed [DATA_W-1:0] action_a [NJ];
  ctl_t                     ctl;

  assign cfg_ready_o = 1'b1;

  // Gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NJ; j++) begin
        gain_p_q[j] <= GAIN_P_RST[j];
        gain_d_q[j] <= GAIN_D_RST[j];
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_GAIN_P_0: gain_p_q[0] <= cfg_data_i;
        CFG_GAIN_P_1: gain_p_q[1] <= cfg_data_i;
        CFG_GAIN_P_2: gain_p_q[2] <= cfg_data_i;
        CFG_GAIN_P_3: gain_p_q[3] <= cfg_data_i;
        CFG_GAIN_D_0: gain_d_q[0] <= cfg_data_i;
        CFG_GAIN_D_1: gain_d_q[1] <= cfg_data_i;
        CFG_GAIN_D_2: gain_d_q[2] <= cfg_data_i;
        CFG_GAIN_D_3: gain_d_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pos_a[0] = pos_0_i;
  assign pos_a[1] = pos_1_i;
  assign pos_a[2] = pos_2_i;
  assign pos_a[3] = pos_3_i;
  assign ref_a[0] = ref_0_i;
  assign ref_a[1] = ref_1_i;
  assign ref_a[2] = ref_2_i;
  assign ref_a[3] = ref_3_i;

  // Pipeline control, trial index and fill counts
  pdilc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .last_sample_i  (last_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_index_o (sample_index_o),
    .ctl_o          (ctl)
  );

  // One datapath lane per joint; unused joints drive zero
  for (genvar j = 0; j < NJ; j++) begin : g_joint
    if (j < JOINTS) begin : g_on
      pdilc_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .pos_i    (pos_a[j]),
        .ref_i    (ref_a[j]),
        .gain_p_i (gain_p_q[j]),
        .gain_d_i (gain_d_q[j]),
        .action_o (action_a[j])
      );
    end else begin : g_off
      assign action_a[j] = '0;
    end
  end

  assign action_0_o = action_a[0];
  assign action_1_o = action_a[1];
  assign action_2_o = action_a[2];
  assign action_3_o = action_a[3];

`ifndef SYNTHESIS
  // The input only stalls when the output holds an item and is stalled
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while pipeline has room");

  // Trial index stays inside the store
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FILL_W'(ctl.rd_idx) < FILL_W'(TRAJ_DEPTH))
    else $error("trial index beyond store depth");

  // Written rows form a prefix: a written next row implies a written row
  a_fill_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.v1 && ctl.ok_next1) |-> ctl.ok_this1)
    else $error("error store fill count out of order");
`endif

endmodule
